[src/sct_pkg.sv]
package sct_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 16;
    localparam int DK_W  = 5;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef struct packed {
        logic                    opcode;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [DK_W-1:0] distinct_keys;
    } t_rsp;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } t_entry;

endpackage

[src/sorted_count_table_core.sv]
// Sorted table of distinct signed keys, each with a 16-bit occurrence count.
//
// Requests arrive on i_valid/i_req and are taken at a rising edge where
// i_valid is high and o_stall is low. An insert adds one to the count of a
// key already held (saturating at the count maximum) or places a new key in
// ascending order with count one; a full table answers with the full status.
// A remove takes one from the count and deletes the entry when it reaches
// zero; an absent key answers with the not-found status. Every request gives
// one response on o_valid/o_rsp with the status and the number of distinct
// keys held afterwards.
//
// One request is worked at a time. The search reads and then compares one
// entry at a time from the bottom; an insert or delete moves each entry above
// the position with a read and then a write, and a new key is then written at
// its place. The entries examined and the entries moved never number more
// than TABLE_DEPTH together. o_stall is high from acceptance until the
// response enters the output register, so the next request can be taken as
// soon as o_valid rises. A stalled response waits there and keeps the next
// response in the finish step. Reset empties the table at once.
module sorted_count_table_core #(
    parameter int TABLE_DEPTH = sct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sct_pkg::t_req i_req,
    output logic          o_stall,
    output logic          o_valid,
    output sct_pkg::t_rsp o_rsp,
    input  logic          i_stall
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_SRD  = 3'd1;  // read the entry at the search position
    localparam logic [2:0] ST_SCMP = 3'd2;  // compare that entry with the key
    localparam logic [2:0] ST_DEC  = 3'd3;  // decide what the request does
    localparam logic [2:0] ST_SHRD = 3'd4;  // read the entry to be moved
    localparam logic [2:0] ST_SHWR = 3'd5;  // write it one place up or down
    localparam logic [2:0] ST_INS  = 3'd6;  // write the new key at its place
    localparam logic [2:0] ST_FIN  = 3'd7;  // hand the response to the output

    logic [2:0]                      r_state, n_state;
    logic                            r_op, n_op;
    logic signed [sct_pkg::KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]                   r_pos, n_pos;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_used, n_used;
    logic                            r_found, n_found;
    logic [sct_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [1:0]                      r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    sct_pkg::t_rsp                   r_rsp, n_rsp;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    sct_pkg::t_entry w_wdata;
    sct_pkg::t_entry w_rdata;
    logic            w_accept;
    logic            w_load;

    sct_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    // The response enters the output register once that register is free
    // or is being emptied in this same cycle.
    assign w_load   = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_used   = r_used;
        n_found  = r_found;
        n_cnt    = r_cnt;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = w_rdata;
        w_raddr  = r_pos[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op     = i_req.opcode;
                    n_key    = i_req.key;
                    n_pos    = '0;
                    n_found  = 1'b0;
                    n_status = sct_pkg::STS_DONE;
                    n_state  = (r_used == '0) ? ST_DEC : ST_SRD;
                end
            end
            ST_SRD: begin
                w_raddr = r_pos[AW-1:0];
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                // Stop at the first entry whose key is not below the request key.
                if (w_rdata.key < r_key) begin
                    n_pos   = r_pos + CW'(1);
                    n_state = (r_pos + CW'(1) == r_used) ? ST_DEC : ST_SRD;
                end else begin
                    n_found = (w_rdata.key == r_key);
                    n_cnt   = w_rdata.count;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_state = ST_FIN;
                if (r_op == sct_pkg::OP_INSERT) begin
                    if (r_found) begin
                        w_we          = 1'b1;
                        w_waddr       = r_pos[AW-1:0];
                        w_wdata.key   = r_key;
                        w_wdata.count = (r_cnt == sct_pkg::COUNT_MAX) ? r_cnt
                                                                      : r_cnt + 1'b1;
                    end else if (r_used == DEPTH_C) begin
                        n_status = sct_pkg::STS_FULL;
                    end else if (r_used == r_pos) begin
                        n_state = ST_INS;
                    end else begin
                        n_idx   = r_used;
                        n_state = ST_SHRD;
                    end
                end else begin
                    if (!r_found) begin
                        n_status = sct_pkg::STS_NOT_FOUND;
                    end else if (r_cnt > sct_pkg::CNT_W'(1)) begin
                        w_we          = 1'b1;
                        w_waddr       = r_pos[AW-1:0];
                        w_wdata.key   = r_key;
                        w_wdata.count = r_cnt - 1'b1;
                    end else if (r_pos + CW'(1) == r_used) begin
                        // Deleting the top entry needs no move.
                        n_used = r_used - CW'(1);
                    end else begin
                        n_idx   = r_pos;
                        n_state = ST_SHRD;
                    end
                end
            end
            ST_SHRD: begin
                // Insert opens a gap by moving entries up, from the top down;
                // delete closes one by moving entries down, from the gap up.
                if (r_op == sct_pkg::OP_INSERT) begin
                    w_raddr = AW'(r_idx - CW'(1));
                end else begin
                    w_raddr = AW'(r_idx + CW'(1));
                end
                n_state = ST_SHWR;
            end
            ST_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
                if (r_op == sct_pkg::OP_INSERT) begin
                    if (r_idx - CW'(1) == r_pos) begin
                        n_state = ST_INS;
                    end else begin
                        n_idx   = r_idx - CW'(1);
                        n_state = ST_SHRD;
                    end
                end else begin
                    if (r_idx + CW'(2) == r_used) begin
                        n_used  = r_used - CW'(1);
                        n_state = ST_FIN;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_SHRD;
                    end
                end
            end
            ST_INS: begin
                w_we          = 1'b1;
                w_waddr       = r_pos[AW-1:0];
                w_wdata.key   = r_key;
                w_wdata.count = sct_pkg::CNT_W'(1);
                n_used        = r_used + CW'(1);
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = i_stall ? r_out_valid : 1'b0;
        n_rsp       = r_rsp;
        if (w_load) begin
            n_out_valid         = 1'b1;
            n_rsp.status        = r_status;
            // The field is five bits; a deeper table reports the count modulo 32.
            n_rsp.distinct_keys = sct_pkg::DK_W'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // The number of held keys never exceeds the table depth.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_C)
        else $error("entry count above table depth");

    // A response appears only after the sequencer has finished a request.
    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_FIN)
        else $error("response raised outside the finish step");

    // A full status is only reported with the table at its depth.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == sct_pkg::STS_FULL)
            |-> o_rsp.distinct_keys == sct_pkg::DK_W'(TABLE_DEPTH))
        else $error("full status with room left");

    // An accepted request always starts the sequencer.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted request left the sequencer idle");

endmodule

[src/sct_ram.sv]
module sct_ram #(
    parameter int DEPTH = sct_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  sct_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output sct_pkg::t_entry      o_rdata
);

    // Simple dual-port entry store with a registered read.
    sct_pkg::t_entry r_mem [DEPTH];
    sct_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/sorted_count_table_core_tb.sv]
module sorted_count_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = sct_pkg::DEFAULT_TABLE_DEPTH;
    localparam int POOL_SIZE   = 20;
    localparam int RANDOM_REQS = 1850;

    localparam logic signed [sct_pkg::KEY_W-1:0] KEY_MIN =
        {1'b1, {(sct_pkg::KEY_W-1){1'b0}}};
    localparam logic signed [sct_pkg::KEY_W-1:0] KEY_MAX =
        {1'b0, {(sct_pkg::KEY_W-1){1'b1}}};

    // Receiver back-pressure styles. The stall pattern steps between them on
    // its own schedule so that stalls land on every phase of a request.
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    sct_pkg::t_req i_req   = '0;
    logic          i_stall = 1'b0;
    logic          o_stall;
    logic          o_valid;
    sct_pkg::t_rsp o_rsp;

    sorted_count_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_req  (i_req),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_rsp  (o_rsp),
        .i_stall(i_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The testbench keeps its own copy of the sorted table. Entries at or
    // above held_keys are never read, just like in the block.
    logic signed [sct_pkg::KEY_W-1:0] table_key [TABLE_DEPTH];
    logic [sct_pkg::CNT_W-1:0]        table_cnt [TABLE_DEPTH];
    int                               held_keys = 0;

    // Responses predicted for accepted requests, oldest first.
    sct_pkg::t_rsp pending_rsp[$];
    int            mismatch_count = 0;

    // Sender pacing: requests go out in bursts with gaps in between.
    int burst_left = 0;

    // Keys that one random phase draws from. A small pool gives repeated
    // hits, which is what drives counts up and entries in and out.
    logic signed [sct_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    // Apply one request to the table copy and return the response it must
    // produce. The search finds the first entry whose key is not below the
    // request key in signed order; an insert shifts the entries above that
    // point up one place and a delete shifts them down.
    function automatic sct_pkg::t_rsp apply_request(input sct_pkg::t_req req);
        sct_pkg::t_rsp rsp;
        int            pos;
        int            i;
        bit            hit;
        pos = 0;
        while (pos < held_keys && $signed(table_key[pos]) < $signed(req.key))
            pos++;
        hit = (pos < held_keys) && (table_key[pos] == req.key);
        rsp.status = sct_pkg::STS_DONE;
        if (req.opcode == sct_pkg::OP_INSERT) begin
            if (hit) begin
                // Counts stick at their maximum rather than wrapping.
                if (table_cnt[pos] != sct_pkg::COUNT_MAX)
                    table_cnt[pos] = table_cnt[pos] + 1'b1;
            end else if (held_keys >= TABLE_DEPTH) begin
                rsp.status = sct_pkg::STS_FULL;
            end else begin
                for (i = held_keys; i > pos; i--) begin
                    table_key[i] = table_key[i-1];
                    table_cnt[i] = table_cnt[i-1];
                end
                table_key[pos] = req.key;
                table_cnt[pos] = sct_pkg::CNT_W'(1);
                held_keys++;
            end
        end else begin
            if (!hit) begin
                rsp.status = sct_pkg::STS_NOT_FOUND;
            end else if (table_cnt[pos] > 1) begin
                table_cnt[pos] = table_cnt[pos] - 1'b1;
            end else begin
                // Last occurrence gone: the entry leaves the table.
                for (i = pos; i < held_keys - 1; i++) begin
                    table_key[i] = table_key[i+1];
                    table_cnt[i] = table_cnt[i+1];
                end
                held_keys--;
            end
        end
        rsp.distinct_keys = sct_pkg::DK_W'(held_keys);
        return rsp;
    endfunction

    // Present one request and hold it until the block takes it. Valid is
    // never lowered between two requests of the same burst, so each edge
    // sees at most one update of i_valid.
    task automatic send_req(input logic op,
                            input logic signed [sct_pkg::KEY_W-1:0] key);
        sct_pkg::t_req req;
        int            gap;
        req.opcode = op;
        req.key    = key;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                              : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_rsp.push_back(apply_request(req));
    endtask

    // Stop sending and wait until every predicted response has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Empty table, the key extremes, sign ordering, and removal at the
    // bottom, the middle and the top of the table.
    task automatic test_extreme_keys();
        send_req(sct_pkg::OP_REMOVE, '0);          // absent key on an empty table
        send_req(sct_pkg::OP_INSERT, KEY_MAX);
        send_req(sct_pkg::OP_INSERT, KEY_MIN);
        send_req(sct_pkg::OP_INSERT, '0);
        send_req(sct_pkg::OP_INSERT, -1);
        send_req(sct_pkg::OP_INSERT, 1);
        send_req(sct_pkg::OP_INSERT, KEY_MAX);     // count goes to two
        send_req(sct_pkg::OP_REMOVE, KEY_MAX);     // back to one, entry stays
        send_req(sct_pkg::OP_REMOVE, 12345);       // absent key on a filled table
        send_req(sct_pkg::OP_REMOVE, KEY_MAX);     // top entry leaves
        send_req(sct_pkg::OP_REMOVE, KEY_MIN);     // bottom entry leaves
        send_req(sct_pkg::OP_REMOVE, '0);          // middle entry leaves
        send_req(sct_pkg::OP_REMOVE, -1);
        send_req(sct_pkg::OP_REMOVE, 1);           // table is empty again
        wait_drained();
    endtask

    // Fill the table in descending order, so every insert lands at the
    // bottom and moves all entries, then push against the full limit.
    task automatic test_full_table();
        int k;
        for (k = TABLE_DEPTH; k > 0; k--)
            send_req(sct_pkg::OP_INSERT, k * 32'h0101_0101);
        send_req(sct_pkg::OP_INSERT, 32'h7777_0000);        // new key, no room
        send_req(sct_pkg::OP_INSERT, 3 * 32'h0101_0101);    // held key still counts
        send_req(sct_pkg::OP_REMOVE, 3 * 32'h0101_0101);
        send_req(sct_pkg::OP_REMOVE, 3 * 32'h0101_0101);    // middle entry leaves
        send_req(sct_pkg::OP_INSERT, 32'h8000_7777);        // room again
        wait_drained();
    endtask

    // One random request. Inserts mostly reuse held or pooled keys so the
    // table fills and counts climb; removes mostly hit held keys so entries
    // actually leave. A share of fully random keys keeps the noise in.
    task automatic send_random(input int insert_pct);
        logic signed [sct_pkg::KEY_W-1:0] k;
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < insert_pct) begin
            if (roll < 12)
                k = $urandom;
            else if (roll < 45 && held_keys > 0)
                k = table_key[$urandom_range(0, held_keys - 1)];
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_req(sct_pkg::OP_INSERT, k);
        end else begin
            if (roll < 10)
                k = $urandom;
            else if (roll < 75 && held_keys > 0)
                k = table_key[$urandom_range(0, held_keys - 1)];
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_req(sct_pkg::OP_REMOVE, k);
        end
    endtask

    // Random traffic in phases: filling, draining and balanced. Each phase
    // draws a fresh key pool, seeded with the extremes and with key pairs
    // that differ only in the sign bit to exercise the signed ordering.
    task automatic test_random_traffic();
        int sent;
        int phase;
        int plen;
        int insert_pct;
        int i;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQS) begin
            for (i = 0; i < POOL_SIZE; i += 2) begin
                key_pool[i]   = $urandom;
                key_pool[i+1] = key_pool[i] ^ KEY_MIN;
            end
            key_pool[0] = KEY_MIN;
            key_pool[1] = KEY_MAX;
            key_pool[2] = '0;
            key_pool[3] = -1;
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 25;
                default: insert_pct = 55;
            endcase
            plen = $urandom_range(40, 160);
            for (i = 0; i < plen; i++)
                send_random(insert_pct);
            sent += plen;
            phase++;
            // Every third phase the sender holds off until the block has
            // answered everything outstanding.
            if (phase % 3 == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver stall pattern, independent of the sender.
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            default:  i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Every response the receiver takes is matched against the oldest
    // prediction, one field at a time.
    always @(posedge i_clk) begin
        sct_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response: expected none, %s%0d %s%0d",
                         $time, "actual status=", o_rsp.status,
                         "distinct_keys=", o_rsp.distinct_keys);
                mismatch_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_rsp.status);
                    mismatch_count++;
                end
                if (o_rsp.distinct_keys !== want.distinct_keys) begin
                    $display("%0t: distinct_keys mismatch: expected %0d, actual %0d",
                             $time, want.distinct_keys, o_rsp.distinct_keys);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_keys();
        test_full_table();
        test_random_traffic();

        // Nothing is outstanding now; give the block time to show any
        // response it should not produce, then report.
        repeat (4 * TABLE_DEPTH + 8) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d responses still expected at the end",
                     $time, pending_rsp.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS sorted_count_table_core");
        end else begin
            $display("FAIL sorted_count_table_core");
        end
        $finish;
    end

    // About two thousand requests, even with long send gaps and heavy receiver
    // stalls, finish well inside this bound.
    initial begin
        #10ms;
        $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
        $display("FAIL sorted_count_table_core");
        $finish;
    end

endmodule
